[rtl/core/lsms_pkg.sv]
package lsms_pkg;

  localparam int PHASE_W   = 3;
  localparam int MEAN_W    = 10;
  localparam int ADC_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_OFF       = 3'd0;
  localparam logic [PHASE_W-1:0] PH_REQ       = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SAMPLING  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SAMPLED   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_EVALUATED = 3'd4;
  localparam logic [PHASE_W-1:0] PH_PUBLISHED = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_CONNECTED = 2'd1;

  localparam logic [MEAN_W-1:0] THRESHOLD_RESET = 10'd6;
  localparam logic [MEAN_W-1:0] LAST_MEAN_RESET = 10'd999;

  typedef struct packed {
    logic [MEAN_W-1:0] dark_threshold;
    logic              link_connected;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               power_on;
    logic               dark_indicator;
    logic               publish_now;
    logic [MEAN_W-1:0]  mean_value;
    logic               bright_level;
    logic               link_error;
  } res_t;

endpackage

[rtl/core/lsms_div.sv]
module lsms_div #(
  parameter int ADC_BITS      = 10,
  parameter int AVERAGE_LIMIT = 10
) (
  input  logic [ADC_BITS+$clog2(AVERAGE_LIMIT+1)-1:0] sum,
  output logic [ADC_BITS-1:0]                         quot
);

  localparam int DIVISOR = AVERAGE_LIMIT + 1;
  localparam int SHIFT_L = $clog2(DIVISOR);
  localparam int SUM_W   = ADC_BITS + SHIFT_L;
  localparam int SHIFT   = SUM_W + SHIFT_L;
  localparam int PROD_W  = 2 * SUM_W + 1;
  // rounded-up reciprocal: exact quotient for every SUM_W-bit sum
  localparam int unsigned RECIP = ((32'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;

  logic [SUM_W:0]    recip;
  logic [PROD_W-1:0] prod;

  assign recip = (SUM_W+1)'(RECIP);
  assign prod  = PROD_W'(sum) * PROD_W'(recip);
  assign quot  = prod[SHIFT +: ADC_BITS];

endmodule

[rtl/core/lsms_core.sv]
module lsms_core #(
  parameter int ADC_BITS      = 10,
  parameter int AVERAGE_LIMIT = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [lsms_pkg::ADC_W-1:0]  adc,
  input  lsms_pkg::cfg_t              cfg,
  output lsms_pkg::res_t              res
);

  localparam int TALLY_W = $clog2(AVERAGE_LIMIT + 1);
  localparam int SUM_W   = ADC_BITS + TALLY_W;

  logic [lsms_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [SUM_W-1:0]             sample_sum_r, sample_sum_nxt;
  logic [TALLY_W-1:0]           sample_tally_r, sample_tally_nxt;
  logic [lsms_pkg::MEAN_W-1:0]  mean_r, mean_nxt;
  logic                         level_r, level_nxt;
  logic                         last_level_r, last_level_nxt;
  logic [lsms_pkg::MEAN_W-1:0]  last_mean_r, last_mean_nxt;
  logic                         supply_r, supply_nxt;
  logic                         indicator_r, indicator_nxt;
  logic                         pub, err;

  logic [SUM_W-1:0]    sum_add;
  logic [ADC_BITS-1:0] quot;

  // bits above ADC_BITS are ignored
  assign sum_add = sample_sum_r + SUM_W'(adc[ADC_BITS-1:0]);

  lsms_div #(
    .ADC_BITS      (ADC_BITS),
    .AVERAGE_LIMIT (AVERAGE_LIMIT)
  ) u_div (
    .sum  (sum_add),
    .quot (quot)
  );

  always_comb begin
    phase_nxt        = phase_r;
    sample_sum_nxt   = sample_sum_r;
    sample_tally_nxt = sample_tally_r;
    mean_nxt         = mean_r;
    level_nxt        = level_r;
    last_level_nxt   = last_level_r;
    last_mean_nxt    = last_mean_r;
    supply_nxt       = supply_r;
    indicator_nxt    = indicator_r;
    pub              = 1'b0;
    err              = 1'b0;
    case (phase_r)
      lsms_pkg::PH_OFF: begin
        sample_sum_nxt   = '0;
        sample_tally_nxt = '0;
        phase_nxt        = lsms_pkg::PH_REQ;
      end
      lsms_pkg::PH_REQ: begin
        supply_nxt = 1'b1;
        phase_nxt  = lsms_pkg::PH_SAMPLING;
      end
      lsms_pkg::PH_SAMPLING: begin
        if (sample_tally_r == TALLY_W'(AVERAGE_LIMIT)) begin
          mean_nxt         = lsms_pkg::MEAN_W'(quot);
          sample_sum_nxt   = '0;
          sample_tally_nxt = '0;
          phase_nxt        = lsms_pkg::PH_SAMPLED;
        end else begin
          sample_sum_nxt   = sum_add;
          sample_tally_nxt = sample_tally_r + TALLY_W'(1);
        end
      end
      lsms_pkg::PH_SAMPLED: begin
        level_nxt     = !(mean_r <= cfg.dark_threshold);
        indicator_nxt = (mean_r <= cfg.dark_threshold);
        supply_nxt    = 1'b0;
        phase_nxt     = lsms_pkg::PH_EVALUATED;
      end
      lsms_pkg::PH_EVALUATED: begin
        if (cfg.link_connected) begin
          if (level_r != last_level_r || mean_r != last_mean_r) begin
            last_level_nxt = level_r;
            last_mean_nxt  = mean_r;
            pub            = 1'b1;
          end
        end else begin
          err = 1'b1;
        end
        phase_nxt = lsms_pkg::PH_PUBLISHED;
      end
      default: begin
        phase_nxt = lsms_pkg::PH_OFF;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= lsms_pkg::PH_OFF;
      sample_sum_r   <= '0;
      sample_tally_r <= '0;
      mean_r         <= '0;
      level_r        <= 1'b0;
      last_level_r   <= 1'b1;
      last_mean_r    <= lsms_pkg::LAST_MEAN_RESET;
      supply_r       <= 1'b0;
      indicator_r    <= 1'b0;
    end else if (fire) begin
      phase_r        <= phase_nxt;
      sample_sum_r   <= sample_sum_nxt;
      sample_tally_r <= sample_tally_nxt;
      mean_r         <= mean_nxt;
      level_r        <= level_nxt;
      last_level_r   <= last_level_nxt;
      last_mean_r    <= last_mean_nxt;
      supply_r       <= supply_nxt;
      indicator_r    <= indicator_nxt;
    end
  end

  always_comb begin
    res.phase          = phase_nxt;
    res.power_on       = supply_nxt;
    res.dark_indicator = indicator_nxt;
    res.publish_now    = pub;
    res.mean_value     = mean_nxt;
    res.bright_level   = level_nxt;
    res.link_error     = err;
  end

  a_supply_phase: assert property (@(posedge clk) disable iff (!rst_n)
    supply_r |-> (phase_r == lsms_pkg::PH_SAMPLING || phase_r == lsms_pkg::PH_SAMPLED))
    else $error("sensor powered outside sampling");

  a_tally_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (sample_tally_r != '0) |-> (phase_r == lsms_pkg::PH_SAMPLING))
    else $error("sample tally left over outside sampling");

  a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= lsms_pkg::PH_PUBLISHED)
    else $error("phase register holds an unused code");

endmodule

[rtl/core/light_sensor_measure_sequencer_top.sv]
// Accepted beats wait in the input register until the sequencer steps; results
// go out from the result register. One input beat per cycle while out_ready is
// high; the phase sequencer makes one step per beat and the mean is a single
// reciprocal multiply in that step. Reset: rst_n is synchronous, active low; it
// clears the sequencer, accumulator, last report and registers to defaults.
module light_sensor_measure_sequencer_top #(
  parameter int AVERAGE_LIMIT = 10,
  parameter int ADC_BITS      = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lsms_pkg::ADC_W-1:0]      in_adc_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lsms_pkg::PHASE_W-1:0]    out_phase,
  output logic                            out_power_on,
  output logic                            out_dark_indicator,
  output logic                            out_publish_now,
  output logic [lsms_pkg::MEAN_W-1:0]     out_mean_value,
  output logic                            out_bright_level,
  output logic                            out_link_error,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lsms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsms_pkg::CFG_DAT_W-1:0]  cfg_data
);

  logic                       in_valid_r;
  logic [lsms_pkg::ADC_W-1:0] adc_r;
  logic                       out_valid_r;
  lsms_pkg::res_t             out_res_r;
  lsms_pkg::res_t             res;
  lsms_pkg::cfg_t             cfg_r;
  logic                       fire;

  assign fire      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dark_threshold <= lsms_pkg::THRESHOLD_RESET;
      cfg_r.link_connected <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        lsms_pkg::REG_DARK_THRESHOLD: cfg_r.dark_threshold <= cfg_data;
        lsms_pkg::REG_LINK_CONNECTED: cfg_r.link_connected <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      adc_r <= in_adc_sample;
    end
  end

  lsms_core #(
    .ADC_BITS      (ADC_BITS),
    .AVERAGE_LIMIT (AVERAGE_LIMIT)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .adc   (adc_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_phase          = out_res_r.phase;
  assign out_power_on       = out_res_r.power_on;
  assign out_dark_indicator = out_res_r.dark_indicator;
  assign out_publish_now    = out_res_r.publish_now;
  assign out_mean_value     = out_res_r.mean_value;
  assign out_bright_level   = out_res_r.bright_level;
  assign out_link_error     = out_res_r.link_error;

  a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("stepped beat did not reach result register");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !fire) |=> (in_valid_r && $stable(adc_r)))
    else $error("waiting input beat lost");

  a_report_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.publish_now || out_res_r.link_error)) |->
      (out_res_r.phase == lsms_pkg::PH_PUBLISHED))
    else $error("report flag outside publish step");

endmodule

[sim/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AVG_LIMIT    = 10;
  localparam int ADC_BITS_P   = 10;
  localparam int ADC_MAX      = (1 << lsms_pkg::ADC_W) - 1;
  localparam int ADC_MASK     = (1 << ADC_BITS_P) - 1;
  localparam int N_ITEMS      = 1000;
  localparam int QUIET_ITEMS  = 150;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 150;
  localparam int STUCK_LIMIT  = 2000;

  typedef enum int {FEED_CONST, FEED_ANY, FEED_LOW, FEED_NEAR_THR, FEED_HIGH} feed_t;

  typedef struct {
    logic [lsms_pkg::ADC_W-1:0] reading;
    bit                         typed;
    lsms_pkg::res_t             want;
  } dir_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [lsms_pkg::ADC_W-1:0]      in_adc_sample;
  logic                            out_valid;
  logic                            out_ready;
  logic [lsms_pkg::PHASE_W-1:0]    out_phase;
  logic                            out_power_on;
  logic                            out_dark_indicator;
  logic                            out_publish_now;
  logic [lsms_pkg::MEAN_W-1:0]     out_mean_value;
  logic                            out_bright_level;
  logic                            out_link_error;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [lsms_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [lsms_pkg::CFG_DAT_W-1:0]  cfg_data;

  // sequencer shadow state
  logic [lsms_pkg::PHASE_W-1:0]  seq_ph;
  logic [15:0]                   acc_sum;
  logic [5:0]                    acc_cnt;
  logic [lsms_pkg::MEAN_W-1:0]   avg_reg;
  logic                          lvl_reg;
  logic                          rep_level;
  logic [lsms_pkg::MEAN_W-1:0]   rep_mean;
  logic                          supply_on;
  logic                          led_on;
  logic [lsms_pkg::MEAN_W-1:0]   thr_cfg;
  logic                          link_up_cfg;

  lsms_pkg::res_t report_q[$];
  dir_row_t       dir_tab[16];
  int unsigned    sent, got, stuck_cycles;
  int unsigned    n_rounds, n_pub, n_same, n_err, n_dark;
  bit             failed;
  bit             src_gaps, snk_gaps;
  bit             hold_go;

  light_sensor_measure_sequencer_top #(
    .AVERAGE_LIMIT (AVG_LIMIT),
    .ADC_BITS      (ADC_BITS_P)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_adc_sample      (in_adc_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_phase          (out_phase),
    .out_power_on       (out_power_on),
    .out_dark_indicator (out_dark_indicator),
    .out_publish_now    (out_publish_now),
    .out_mean_value     (out_mean_value),
    .out_bright_level   (out_bright_level),
    .out_link_error     (out_link_error),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [lsms_pkg::MEAN_W-1:0] clamp_code(input int v);
    if (v < 0) return '0;
    if (v > ADC_MAX) return '1;
    return lsms_pkg::MEAN_W'(v);
  endfunction

  // advance the shadow sequencer by one step and return the report it shows
  function automatic lsms_pkg::res_t step_sequencer(input logic [lsms_pkg::ADC_W-1:0] raw);
    logic [lsms_pkg::ADC_W-1:0] rd;
    logic [15:0]                sum;
    int unsigned                cnt;
    lsms_pkg::res_t             r;
    rd = raw & lsms_pkg::ADC_W'(ADC_MASK);
    r = '0;
    case (seq_ph)
      lsms_pkg::PH_OFF: begin
        acc_sum = '0;
        acc_cnt = '0;
        seq_ph  = lsms_pkg::PH_REQ;
      end
      lsms_pkg::PH_REQ: begin
        supply_on = 1'b1;
        seq_ph    = lsms_pkg::PH_SAMPLING;
      end
      lsms_pkg::PH_SAMPLING: begin
        sum = acc_sum + 16'(rd);
        cnt = acc_cnt + 1;
        if (cnt > AVG_LIMIT) begin
          avg_reg = lsms_pkg::MEAN_W'(sum / cnt);
          acc_sum = '0;
          acc_cnt = '0;
          seq_ph  = lsms_pkg::PH_SAMPLED;
        end else begin
          acc_sum = sum;
          acc_cnt = 6'(cnt);
        end
      end
      lsms_pkg::PH_SAMPLED: begin
        lvl_reg   = (avg_reg <= thr_cfg) ? 1'b0 : 1'b1;
        led_on    = ~lvl_reg;
        supply_on = 1'b0;
        seq_ph    = lsms_pkg::PH_EVALUATED;
      end
      lsms_pkg::PH_EVALUATED: begin
        if (link_up_cfg) begin
          if (lvl_reg != rep_level || avg_reg != rep_mean) begin
            rep_level     = lvl_reg;
            rep_mean      = avg_reg;
            r.publish_now = 1'b1;
          end
        end else begin
          r.link_error = 1'b1;
        end
        seq_ph = lsms_pkg::PH_PUBLISHED;
      end
      default: seq_ph = lsms_pkg::PH_OFF;
    endcase
    r.phase          = seq_ph;
    r.power_on       = supply_on;
    r.dark_indicator = led_on;
    r.mean_value     = avg_reg;
    r.bright_level   = lvl_reg;
    return r;
  endfunction

  // called at a falling edge; leaves valid high after the beat is taken
  task automatic offer_reading(input logic [lsms_pkg::ADC_W-1:0] rd, input bit typed,
                               input lsms_pkg::res_t want);
    lsms_pkg::res_t pred;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid      = 1'b1;
    in_adc_sample = rd;
    do @(posedge clk); while (!in_ready);
    pred = step_sequencer(rd);
    report_q.push_back(typed ? want : pred);
    sent++;
    if (pred.phase == lsms_pkg::PH_PUBLISHED) begin
      n_rounds++;
      if (pred.publish_now) n_pub++;
      else if (pred.link_error) n_err++;
      else n_same++;
    end
    if (pred.phase == lsms_pkg::PH_EVALUATED && pred.dark_indicator) n_dark++;
    @(negedge clk);
  endtask

  // drain the block, then write both registers back to back
  task automatic load_settings(input logic [lsms_pkg::CFG_DAT_W-1:0] thr, input logic link);
    in_valid = 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    for (int i = 0; i < 2; i++) begin
      cfg_valid = 1'b1;
      cfg_index = (i == 0) ? lsms_pkg::REG_DARK_THRESHOLD : lsms_pkg::REG_LINK_CONNECTED;
      cfg_data  = (i == 0) ? thr : lsms_pkg::CFG_DAT_W'(link);
      do @(posedge clk); while (!cfg_ready);
      if (cfg_index == lsms_pkg::REG_DARK_THRESHOLD) thr_cfg = cfg_data;
      else link_up_cfg = cfg_data[0];
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned seen);
    if (want != seen) begin
      $error("%s expected %0d got %0d", name, want, seen);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin : check_results
    lsms_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      got++;
      if (report_q.size() == 0) begin
        $error("result beat with no reading pending");
        failed = 1'b1;
      end else begin
        want = report_q.pop_front();
        check_field("phase", 32'(want.phase), 32'(out_phase));
        check_field("power_on", 32'(want.power_on), 32'(out_power_on));
        check_field("dark_indicator", 32'(want.dark_indicator), 32'(out_dark_indicator));
        check_field("publish_now", 32'(want.publish_now), 32'(out_publish_now));
        check_field("mean_value", 32'(want.mean_value), 32'(out_mean_value));
        check_field("bright_level", 32'(want.bright_level), 32'(out_bright_level));
        check_field("link_error", 32'(want.link_error), 32'(out_link_error));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // result side: random stall bursts plus one long hold to back up the input
  initial begin
    bit held;
    held      = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_n);
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (!held && hold_go) begin
        held      = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ready = 1'b1;
      end else if (snk_gaps && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_ready = 1'b1;
      end
    end
  end

  initial begin
    feed_t                       mode;
    int unsigned                 len;
    logic [lsms_pkg::ADC_W-1:0]  rd, level;
    logic [lsms_pkg::MEAN_W-1:0] thr;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_adc_sample = '0;
    cfg_valid     = 1'b0;
    cfg_index     = lsms_pkg::REG_DARK_THRESHOLD;
    cfg_data      = '0;
    src_gaps      = 1'b1;
    snk_gaps      = 1'b1;
    hold_go       = 1'b0;
    failed        = 1'b0;

    seq_ph      = lsms_pkg::PH_OFF;
    acc_sum     = '0;
    acc_cnt     = '0;
    avg_reg     = '0;
    lvl_reg     = 1'b0;
    rep_level   = 1'b1;
    rep_mean    = lsms_pkg::LAST_MEAN_RESET;
    supply_on   = 1'b0;
    led_on      = 1'b0;
    thr_cfg     = lsms_pkg::THRESHOLD_RESET;
    link_up_cfg = 1'b0;

    // one full round at reset settings, full-scale readings while sampling
    foreach (dir_tab[k]) begin
      dir_tab[k].reading = 10'h3FF;
      dir_tab[k].typed   = 1'b0;
      dir_tab[k].want    = '0;
    end
    dir_tab[0].reading  = 10'h000;
    dir_tab[13].reading = 10'h155;
    dir_tab[14].reading = 10'h2AA;
    dir_tab[15].reading = 10'h000;
    dir_tab[0].typed  = 1'b1;
    dir_tab[0].want   = '{lsms_pkg::PH_REQ, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 1'b0};
    dir_tab[1].typed  = 1'b1;
    dir_tab[1].want   = '{lsms_pkg::PH_SAMPLING, 1'b1, 1'b0, 1'b0, 10'd0, 1'b0, 1'b0};
    dir_tab[12].typed = 1'b1;
    dir_tab[12].want  = '{lsms_pkg::PH_SAMPLED, 1'b1, 1'b0, 1'b0, 10'd1023, 1'b0, 1'b0};
    dir_tab[13].typed = 1'b1;
    dir_tab[13].want  = '{lsms_pkg::PH_EVALUATED, 1'b0, 1'b0, 1'b0, 10'd1023, 1'b1, 1'b0};
    // link is down out of reset
    dir_tab[14].typed = 1'b1;
    dir_tab[14].want  = '{lsms_pkg::PH_PUBLISHED, 1'b0, 1'b0, 1'b0, 10'd1023, 1'b1, 1'b1};
    dir_tab[15].typed = 1'b1;
    dir_tab[15].want  = '{lsms_pkg::PH_OFF, 1'b0, 1'b0, 1'b0, 10'd1023, 1'b1, 1'b0};

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[k]) offer_reading(dir_tab[k].reading, dir_tab[k].typed, dir_tab[k].want);

    while (sent < N_ITEMS) begin
      src_gaps = (sent < N_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 2) != 0);
      snk_gaps = (sent < N_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 4))
        0:       thr = '0;
        1:       thr = '1;
        2:       thr = clamp_code(int'(avg_reg) + int'($urandom_range(0, 6)) - 3);
        default: thr = lsms_pkg::MEAN_W'($urandom_range(0, ADC_MAX));
      endcase
      load_settings(thr, $urandom_range(0, 3) != 0);
      // start the long hold while a whole batch is still to be offered
      if (sent >= HOLD_AFTER) hold_go = 1'b1;
      mode = feed_t'($urandom_range(0, 4));
      case ($urandom_range(0, 3))
        0:       level = '0;
        1:       level = '1;
        2:       level = thr;
        default: level = lsms_pkg::ADC_W'($urandom_range(0, ADC_MAX));
      endcase
      len = $urandom_range(16, 64);
      repeat (len) begin
        case (mode)
          FEED_CONST:    rd = level;
          FEED_ANY:      rd = lsms_pkg::ADC_W'($urandom_range(0, ADC_MAX));
          FEED_LOW:      rd = lsms_pkg::ADC_W'($urandom_range(0, 15));
          FEED_NEAR_THR: rd = clamp_code(int'(thr) + int'($urandom_range(0, 6)) - 3);
          default:       rd = lsms_pkg::ADC_W'($urandom_range(ADC_MAX - 15, ADC_MAX));
        endcase
        offer_reading(rd, 1'b0, '0);
      end
    end

    in_valid = 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    $display("Ran %0d readings through %0d measure rounds under changing threshold and link.",
             sent, n_rounds);
    $display("Rounds: %0d reported, %0d unchanged, %0d link down, %0d dark.",
             n_pub, n_same, n_err, n_dark);
    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[light_sensor_measure_sequencer_top.f]
rtl/core/lsms_pkg.sv
rtl/core/lsms_div.sv
rtl/core/lsms_core.sv
rtl/core/light_sensor_measure_sequencer_top.sv
sim/testbench.sv
